FILE: src/lcdn_pkg.sv
// ----------------------------------------------------------------------------
// lcdn_pkg
// shared types, constants and helpers for the 4-bit character display unit
// ----------------------------------------------------------------------------
package lcdn_pkg;

  // request codes
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_INIT  = 3'd1;
  localparam logic [2:0] REQ_CMD   = 3'd2;
  localparam logic [2:0] REQ_DATA  = 3'd3;
  localparam logic [2:0] REQ_POS   = 3'd4;
  localparam logic [2:0] REQ_CPOS  = 3'd5;
  localparam logic [2:0] REQ_GLYPH = 3'd6;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_WAIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE     = 8'd1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] LONG_WAIT_RST = 16'd30;
  localparam logic [7:0]  PULSE_RST     = 8'd1;

  // row base addresses
  localparam logic [7:0] ROW0_BASE = 8'h80;
  localparam logic [7:0] ROW1_BASE = 8'hC0;
  localparam logic [7:0] ROW2_BASE = 8'h94;
  localparam logic [7:0] ROW3_BASE = 8'hD4;

  // init and glyph bytes
  localparam logic [7:0] INIT_WAKE    = 8'h30;
  localparam logic [7:0] INIT_4BIT    = 8'h20;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0F;
  localparam logic [1:0] CGRAM_PREFIX = 2'b01;  // 0x40 + slot*8
  localparam logic [7:0] CMD_HOME_DD  = 8'h80;

  localparam logic [3:0] INIT_BYTES  = 4'd7;
  localparam logic [3:0] INIT_NIBBLE = 4'd4;   // init units below this are single nibbles
  localparam logic [3:0] GLYPH_BYTES = 4'd10;
  localparam logic [3:0] CPOS_BYTES  = 4'd2;
  localparam logic [3:0] ONE_BYTE    = 4'd1;

  localparam int unsigned QUEUE_DEPTH = 2;

  // sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_POWER = 4'b0010,
    PH_EHIGH = 4'b0100,
    PH_ELOW  = 4'b1000
  } phase_t;

  // classified request word passed from front to back
  typedef struct packed {
    logic [2:0]  kind;
    logic        ok;      // a request that may start a sequence
    logic [7:0]  bv;
    logic [7:0]  addr;
    logic [2:0]  slot;
    logic [63:0] rows;
  } q_entry_t;

  // one result word
  typedef struct packed {
    logic [3:0] data_nibble;
    logic       reg_select;
    logic       enable_line;
    logic       busy_res;
    logic       accepted;
  } res_t;

  function automatic logic [7:0] row_base(input logic [2:0] row);
    logic [7:0] b;
    case (row)
      3'd1:    b = ROW1_BASE;
      3'd2:    b = ROW2_BASE;
      3'd3:    b = ROW3_BASE;
      default: b = ROW0_BASE;
    endcase
    return b;
  endfunction

  function automatic logic single_nibble(input logic [2:0] kind, input logic [3:0] unit);
    return (kind == REQ_INIT) && (unit < INIT_NIBBLE);
  endfunction

  function automatic logic rs_of(input logic [2:0] kind, input logic [3:0] unit);
    logic rs;
    case (kind)
      REQ_DATA:  rs = 1'b1;
      REQ_CPOS:  rs = (unit == 4'd1);
      REQ_GLYPH: rs = (unit inside {[4'd1 : 4'd8]});
      default:   rs = 1'b0;
    endcase
    return rs;
  endfunction

  function automatic logic [7:0] byte_of(input logic [2:0] kind, input logic [3:0] unit,
                                         input logic [7:0] bv, input logic [7:0] addr,
                                         input logic [2:0] slot, input logic [63:0] rows);
    logic [7:0] b;
    logic [5:0] sel;
    sel = {3'(unit[2:0] - 3'd1), 3'b000};
    case (kind)
      REQ_INIT: begin
        case (unit)
          4'd0, 4'd1, 4'd2: b = INIT_WAKE;
          4'd3:             b = INIT_4BIT;
          4'd4:             b = CMD_CLEAR;
          4'd5:             b = CMD_ENTRY;
          default:          b = CMD_DISP_ON;
        endcase
      end
      REQ_POS:  b = addr;
      REQ_CPOS: b = (unit == 4'd0) ? addr : bv;
      REQ_GLYPH: begin
        if (unit == 4'd0) begin
          b = {CGRAM_PREFIX, slot, 3'b000};
        end else if (unit == 4'd9) begin
          b = CMD_HOME_DD;
        end else begin
          b = rows[sel +: 8];
        end
      end
      default:  b = bv;
    endcase
    return b;
  endfunction

endpackage

FILE: src/lcdn_in_if.sv
// ----------------------------------------------------------------------------
// lcdn_in_if
// request channel of the display unit
// ----------------------------------------------------------------------------
interface lcdn_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  byte_value;
  logic [2:0]  row;
  logic [7:0]  col;
  logic [3:0]  glyph_slot;
  logic [63:0] glyph_rows;

  modport source (output valid, req_type, byte_value, row, col, glyph_slot, glyph_rows,
                  input ready);
  modport sink   (input valid, req_type, byte_value, row, col, glyph_slot, glyph_rows,
                  output ready);
endinterface

FILE: src/lcdn_out_if.sv
// ----------------------------------------------------------------------------
// lcdn_out_if
// result channel of the display unit
// ----------------------------------------------------------------------------
interface lcdn_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] data_nibble;
  logic       reg_select;
  logic       enable_line;
  logic       busy_res;
  logic       accepted;

  modport source (output valid, data_nibble, reg_select, enable_line, busy_res, accepted,
                  input ready);
  modport sink   (input valid, data_nibble, reg_select, enable_line, busy_res, accepted,
                  output ready);
endinterface

FILE: src/lcdn_cfg_if.sv
// ----------------------------------------------------------------------------
// lcdn_cfg_if
// configuration write channel of the display unit
// ----------------------------------------------------------------------------
interface lcdn_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lcdn_pkg::CFG_IDX_W-1:0]    index;
  logic [lcdn_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/lcdn_front.sv
// ----------------------------------------------------------------------------
// lcdn_front
// classifies a request word: validity, cursor address, glyph slot
// ----------------------------------------------------------------------------
module lcdn_front (
  input  logic [2:0]         req_type,
  input  logic [7:0]         byte_value,
  input  logic [2:0]         row,
  input  logic [7:0]         col,
  input  logic [3:0]         glyph_slot,
  input  logic [63:0]        glyph_rows,
  output lcdn_pkg::q_entry_t entry
);

  logic is_req;

  always_comb begin
    is_req = (req_type inside {[lcdn_pkg::REQ_INIT : lcdn_pkg::REQ_GLYPH]});
    entry.kind = req_type;
    // out-of-range glyph slot is ignored, like a plain tick
    entry.ok   = is_req && !((req_type == lcdn_pkg::REQ_GLYPH) && glyph_slot[3]);
    entry.bv   = byte_value;
    entry.addr = 8'(lcdn_pkg::row_base(row) + col);
    entry.slot = glyph_slot[2:0];
    entry.rows = glyph_rows;
  end

endmodule

FILE: src/lcdn_queue.sv
// ----------------------------------------------------------------------------
// lcdn_queue
// short fifo of classified words between front and back
// ----------------------------------------------------------------------------
module lcdn_queue #(
  parameter int unsigned DEPTH = lcdn_pkg::QUEUE_DEPTH  // 2 or more
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lcdn_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output lcdn_pkg::q_entry_t head_entry
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lcdn_pkg::q_entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: src/lcdn_back.sv
// ----------------------------------------------------------------------------
// lcdn_back
// pin sequencer: one step per word, result register, config registers
// ----------------------------------------------------------------------------
module lcdn_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              head_valid,
  input  lcdn_pkg::q_entry_t                head_entry,
  output logic                              pop,
  input  logic                              cfg_we,
  input  logic [lcdn_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [lcdn_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                              res_valid,
  output lcdn_pkg::res_t                    res,
  input  logic                              res_ready
);

  lcdn_pkg::phase_t phase_r, phase_nxt;
  logic        half_r, half_nxt;
  logic [3:0]  unit_r, unit_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [5:0]  pins_r, pins_nxt;          // {E, RS, D7..D4}
  logic [2:0]  kind_r, kind_nxt;
  logic [7:0]  bv_r, bv_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [2:0]  slot_r, slot_nxt;
  logic [63:0] rows_r, rows_nxt;
  logic [15:0] long_wait_r;
  logic [7:0]  pulse_r;
  logic        out_valid_r;
  lcdn_pkg::res_t res_r, res_nxt;

  logic        acc;
  logic        do_start;
  logic [3:0]  st_unit;
  logic        st_half;
  logic [4:0]  unit_inc;
  logic [7:0]  st_byte;
  logic [15:0] dur_pulse, dur_long;

  assign pop       = head_valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = res_r;
  assign dur_pulse = (pulse_r == 8'd0) ? 16'd1 : {8'd0, pulse_r};
  assign dur_long  = (long_wait_r == 16'd0) ? 16'd1 : long_wait_r;
  assign unit_inc  = {1'b0, unit_r} + 5'd1;

  always_comb begin
    phase_nxt = phase_r;
    half_nxt  = half_r;
    unit_nxt  = unit_r;
    wait_nxt  = wait_r;
    count_nxt = count_r;
    pins_nxt  = pins_r;
    kind_nxt  = kind_r;
    bv_nxt    = bv_r;
    addr_nxt  = addr_r;
    slot_nxt  = slot_r;
    rows_nxt  = rows_r;
    acc       = 1'b0;
    do_start  = 1'b0;
    st_unit   = 4'd0;
    st_half   = 1'b0;
    st_byte   = 8'd0;

    if (pop) begin
      if (phase_r != lcdn_pkg::PH_IDLE) begin
        if (wait_r > 16'd1) begin
          wait_nxt = wait_r - 16'd1;
        end else begin
          case (phase_r)
            lcdn_pkg::PH_POWER: begin
              do_start = 1'b1;
            end
            lcdn_pkg::PH_EHIGH: begin
              pins_nxt[5] = 1'b0;
              wait_nxt    = lcdn_pkg::single_nibble(kind_r, unit_r) ? dur_long : dur_pulse;
              phase_nxt   = lcdn_pkg::PH_ELOW;
            end
            lcdn_pkg::PH_ELOW: begin
              if (!lcdn_pkg::single_nibble(kind_r, unit_r) && !half_r) begin
                do_start = 1'b1;
                st_unit  = unit_r;
                st_half  = 1'b1;
              end else if (unit_inc >= {1'b0, count_r}) begin
                phase_nxt = lcdn_pkg::PH_IDLE;
                half_nxt  = 1'b0;
                unit_nxt  = 4'd0;
                wait_nxt  = 16'd0;
              end else begin
                do_start = 1'b1;
                st_unit  = unit_inc[3:0];
              end
            end
            default: begin
              phase_nxt = lcdn_pkg::PH_IDLE;
              half_nxt  = 1'b0;
              unit_nxt  = 4'd0;
              wait_nxt  = 16'd0;
            end
          endcase
        end
      end else if (head_entry.ok) begin
        acc      = 1'b1;
        kind_nxt = head_entry.kind;
        bv_nxt   = head_entry.bv;
        addr_nxt = head_entry.addr;
        slot_nxt = head_entry.slot;
        rows_nxt = head_entry.rows;
        case (head_entry.kind)
          lcdn_pkg::REQ_INIT:  count_nxt = lcdn_pkg::INIT_BYTES;
          lcdn_pkg::REQ_CPOS:  count_nxt = lcdn_pkg::CPOS_BYTES;
          lcdn_pkg::REQ_GLYPH: count_nxt = lcdn_pkg::GLYPH_BYTES;
          default:             count_nxt = lcdn_pkg::ONE_BYTE;
        endcase
        if (head_entry.kind == lcdn_pkg::REQ_INIT) begin
          pins_nxt  = 6'd0;
          wait_nxt  = dur_long;
          phase_nxt = lcdn_pkg::PH_POWER;
          half_nxt  = 1'b0;
          unit_nxt  = 4'd0;
        end else begin
          do_start = 1'b1;
        end
      end
    end

    // put a nibble on the bus with E high
    if (do_start) begin
      st_byte   = lcdn_pkg::byte_of(kind_nxt, st_unit, bv_nxt, addr_nxt, slot_nxt, rows_nxt);
      pins_nxt  = {1'b1, lcdn_pkg::rs_of(kind_nxt, st_unit),
                   st_half ? st_byte[3:0] : st_byte[7:4]};
      wait_nxt  = dur_pulse;
      phase_nxt = lcdn_pkg::PH_EHIGH;
      half_nxt  = st_half;
      unit_nxt  = st_unit;
    end

    res_nxt.data_nibble = pins_nxt[3:0];
    res_nxt.reg_select  = pins_nxt[4];
    res_nxt.enable_line = pins_nxt[5];
    res_nxt.busy_res    = (phase_nxt != lcdn_pkg::PH_IDLE);
    res_nxt.accepted    = acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lcdn_pkg::PH_IDLE;
      half_r      <= 1'b0;
      unit_r      <= 4'd0;
      wait_r      <= 16'd0;
      count_r     <= 4'd0;
      pins_r      <= 6'd0;
      kind_r      <= lcdn_pkg::REQ_TICK;
      long_wait_r <= lcdn_pkg::LONG_WAIT_RST;
      pulse_r     <= lcdn_pkg::PULSE_RST;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      half_r  <= half_nxt;
      unit_r  <= unit_nxt;
      wait_r  <= wait_nxt;
      count_r <= count_nxt;
      pins_r  <= pins_nxt;
      kind_r  <= kind_nxt;
      if (cfg_we && (cfg_idx == lcdn_pkg::CFG_LONG_WAIT)) begin
        long_wait_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_idx == lcdn_pkg::CFG_PULSE)) begin
        pulse_r <= cfg_wdata[7:0];
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request payload and result word, no reset needed
  always_ff @(posedge clk) begin
    bv_r   <= bv_nxt;
    addr_r <= addr_nxt;
    slot_r <= slot_nxt;
    rows_r <= rows_nxt;
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: src/char_lcd_nibble_interface_unit.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_unit
// 4-bit character display driver: init, command, data, cursor, glyph words
// ----------------------------------------------------------------------------
//
// channel  dir  handshake     contents
// in_ch    in   valid/ready   req_type, byte_value, row, col, glyph_slot, glyph_rows
// out_ch   out  valid/ready   data_nibble, reg_select, enable_line, busy_res, accepted
// cfg_ch   in   valid/ready   index, data (0 long_wait_ticks, 1 pulse_ticks)
//
// every input word is one tick of the pin sequencer and yields one result word
// sustained rate one word per cycle while out_ch does not stall; a word taken
// passes the queue, then the result register, before it is offered on out_ch
// the sequencer step in the back part sets the rate: one step per word
// in_ch.ready drops only when the queue is full; out_ch stalls back up through it
// cfg_ch.ready is always high; synchronous active-low reset restores defaults
//
module char_lcd_nibble_interface_unit #(
  parameter int unsigned QUEUE_DEPTH = lcdn_pkg::QUEUE_DEPTH  // 2 or more
) (
  input  logic       clk,
  input  logic       rst_n,
  lcdn_in_if.sink    in_ch,
  lcdn_out_if.source out_ch,
  lcdn_cfg_if.sink   cfg_ch
);

  lcdn_pkg::q_entry_t front_entry;
  lcdn_pkg::q_entry_t head_entry;
  lcdn_pkg::res_t     res;
  logic q_full;
  logic q_push;
  logic q_pop;
  logic head_valid;
  logic res_valid;

  // front: classify each word as it comes in
  lcdn_front u_front (
    .req_type   (in_ch.req_type),
    .byte_value (in_ch.byte_value),
    .row        (in_ch.row),
    .col        (in_ch.col),
    .glyph_slot (in_ch.glyph_slot),
    .glyph_rows (in_ch.glyph_rows),
    .entry      (front_entry)
  );

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // queue lets the input side run while the result side stalls
  lcdn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  assign cfg_ch.ready = 1'b1;

  // back: sequencer step and result register
  lcdn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (q_pop),
    .cfg_we     (cfg_ch.valid),
    .cfg_idx    (cfg_ch.index),
    .cfg_wdata  (cfg_ch.data),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (out_ch.ready)
  );

  assign out_ch.valid       = res_valid;
  assign out_ch.data_nibble = res.data_nibble;
  assign out_ch.reg_select  = res.reg_select;
  assign out_ch.enable_line = res.enable_line;
  assign out_ch.busy_res    = res.busy_res;
  assign out_ch.accepted    = res.accepted;

endmodule

FILE: sim/char_lcd_nibble_interface_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_unit_tb
// self-checking bench for the 4-bit character display driver: a shadow
// sequencer predicts the pin levels, busy and accept flags of every word,
// results are compared in order while both channels stall at random
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface_unit_tb;

  localparam logic [2:0]  REQ_SPARE     = 3'd7;       // unused code, acts as a tick
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;          // queue plus result register, with margin
  localparam int unsigned MAX_SHOWN     = 10;

  // one request word as driven on in_ch
  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  byte_value;
    logic [2:0]  row;
    logic [7:0]  col;
    logic [3:0]  glyph_slot;
    logic [63:0] glyph_rows;
  } lcd_word_t;

  // shadow of the pin sequencer, settings included
  typedef struct packed {
    logic [15:0]      long_wait;
    logic [7:0]       pulse;
    lcdn_pkg::phase_t ph;
    logic             half;       // 0 high nibble, 1 low nibble
    logic [3:0]       byte_idx;
    logic [15:0]      cnt;
    logic [10:0][7:0] pend;
    logic [3:0]       nbytes;
    logic [2:0]       kind;
    logic [3:0]       nib;
    logic             rs;
    logic             e;
    logic             took;
  } lcd_state_t;

  logic clk = 1'b0;
  logic rst_n;

  lcdn_in_if  in_ch ();
  lcdn_out_if out_ch ();
  lcdn_cfg_if cfg_ch ();

  char_lcd_nibble_interface_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  lcd_word_t      word_queue[$];       // words waiting for the driver
  lcdn_pkg::res_t expected_levels[$];  // predicted result words, oldest first
  lcd_state_t     plan_state;          // run ahead by the stimulus to place requests
  lcd_state_t     live_state;          // stepped on each accepted word
  int unsigned words_pushed  = 0;
  int unsigned words_checked = 0;
  int unsigned fault_count   = 0;
  int unsigned shown         = 0;
  int unsigned cycle_count   = 0;
  int unsigned gap_pct       = 9;
  logic        in_fired      = 1'b0;
  logic        cfg_fired     = 1'b0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // rs level for a byte of the running request
  function automatic logic rs_level(input logic [2:0] kind, input logic [3:0] idx);
    logic rs;
    case (kind)
      lcdn_pkg::REQ_DATA:  rs = 1'b1;
      lcdn_pkg::REQ_CPOS:  rs = (idx == 4'd1);
      lcdn_pkg::REQ_GLYPH: rs = (idx inside {[4'd1 : 4'd8]});
      default:             rs = 1'b0;
    endcase
    return rs;
  endfunction

  // put one nibble on the bus with e high and start the pulse count
  function automatic lcd_state_t show_nibble(input lcd_state_t s, input logic [3:0] idx,
                                             input logic half);
    logic [7:0] b;
    b      = (idx < 4'd11) ? s.pend[idx] : s.pend[0];
    s.nib  = half ? b[3:0] : b[7:4];
    s.rs   = rs_level(s.kind, idx);
    s.e    = 1'b1;
    s.cnt  = (s.pulse == 8'd0) ? 16'd1 : {8'd0, s.pulse};
    s.ph   = lcdn_pkg::PH_EHIGH;
    s.half = half;
    s.byte_idx = idx;
    return s;
  endfunction

  // one word: a tick of a running sequence, or a request while idle
  function automatic lcd_state_t lcd_next(input lcd_state_t s, input lcd_word_t w);
    logic        single;
    logic [7:0]  base;
    logic [7:0]  addr;
    logic [15:0] long_dur;
    logic [3:0]  nxt_idx;
    single   = (s.kind == lcdn_pkg::REQ_INIT) && (s.byte_idx < lcdn_pkg::INIT_NIBBLE);
    long_dur = (s.long_wait == 16'd0) ? 16'd1 : s.long_wait;
    s.took   = 1'b0;
    if (s.ph != lcdn_pkg::PH_IDLE) begin
      if (s.cnt > 16'd1) begin
        s.cnt = s.cnt - 16'd1;
      end else begin
        case (s.ph)
          lcdn_pkg::PH_POWER: s = show_nibble(s, 4'd0, 1'b0);
          lcdn_pkg::PH_EHIGH: begin
            s.e   = 1'b0;
            s.cnt = single ? long_dur : ((s.pulse == 8'd0) ? 16'd1 : {8'd0, s.pulse});
            s.ph  = lcdn_pkg::PH_ELOW;
          end
          lcdn_pkg::PH_ELOW: begin
            if (!single && !s.half) begin
              s = show_nibble(s, s.byte_idx, 1'b1);
            end else begin
              nxt_idx = s.byte_idx + 4'd1;
              if (nxt_idx >= s.nbytes) begin
                s.ph = lcdn_pkg::PH_IDLE;
                s.half = 1'b0;
                s.byte_idx = 4'd0;
                s.cnt = 16'd0;
              end else begin
                s = show_nibble(s, nxt_idx, 1'b0);
              end
            end
          end
          default: begin
            s.ph = lcdn_pkg::PH_IDLE;
            s.half = 1'b0;
            s.byte_idx = 4'd0;
            s.cnt = 16'd0;
          end
        endcase
      end
    end else if ((w.req_type inside {[lcdn_pkg::REQ_INIT : lcdn_pkg::REQ_GLYPH]}) &&
                 !(w.req_type == lcdn_pkg::REQ_GLYPH && w.glyph_slot >= 4'd8)) begin
      // rows 4 to 7 fall back to the row 0 base
      case (w.row)
        3'd1:    base = lcdn_pkg::ROW1_BASE;
        3'd2:    base = lcdn_pkg::ROW2_BASE;
        3'd3:    base = lcdn_pkg::ROW3_BASE;
        default: base = lcdn_pkg::ROW0_BASE;
      endcase
      addr   = base + w.col;
      s.took = 1'b1;
      s.kind = w.req_type;
      case (w.req_type)
        lcdn_pkg::REQ_INIT: begin
          s.pend[0] = lcdn_pkg::INIT_WAKE;
          s.pend[1] = lcdn_pkg::INIT_WAKE;
          s.pend[2] = lcdn_pkg::INIT_WAKE;
          s.pend[3] = lcdn_pkg::INIT_4BIT;
          s.pend[4] = lcdn_pkg::CMD_CLEAR;
          s.pend[5] = lcdn_pkg::CMD_ENTRY;
          s.pend[6] = lcdn_pkg::CMD_DISP_ON;
          s.nbytes  = lcdn_pkg::INIT_BYTES;
        end
        lcdn_pkg::REQ_POS: begin
          s.pend[0] = addr;
          s.nbytes  = lcdn_pkg::ONE_BYTE;
        end
        lcdn_pkg::REQ_CPOS: begin
          s.pend[0] = addr;
          s.pend[1] = w.byte_value;
          s.nbytes  = lcdn_pkg::CPOS_BYTES;
        end
        lcdn_pkg::REQ_GLYPH: begin
          s.pend[0] = 8'h40 + {1'b0, w.glyph_slot[2:0], 3'b000};
          for (int i = 0; i < 8; i++) s.pend[i + 1] = w.glyph_rows[8 * i +: 8];
          s.pend[9] = lcdn_pkg::CMD_HOME_DD;
          s.nbytes  = lcdn_pkg::GLYPH_BYTES;
        end
        default: begin
          s.pend[0] = w.byte_value;
          s.nbytes  = lcdn_pkg::ONE_BYTE;
        end
      endcase
      if (w.req_type == lcdn_pkg::REQ_INIT) begin
        s.nib = 4'd0;
        s.rs  = 1'b0;
        s.e   = 1'b0;
        s.cnt = long_dur;
        s.ph  = lcdn_pkg::PH_POWER;
        s.half = 1'b0;
        s.byte_idx = 4'd0;
      end else begin
        s = show_nibble(s, 4'd0, 1'b0);
      end
    end
    return s;
  endfunction

  function automatic lcd_state_t apply_reg(input lcd_state_t s,
                                           input logic [lcdn_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [lcdn_pkg::CFG_DATA_W-1:0] val);
    if (idx == lcdn_pkg::CFG_LONG_WAIT) begin
      s.long_wait = val;
    end else if (idx == lcdn_pkg::CFG_PULSE) begin
      s.pulse = val[7:0];
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // word builders
  // ---------------------------------------------------------------------------

  function automatic lcd_word_t word_of(input logic [2:0] kind, input logic [7:0] bv,
                                        input logic [2:0] row, input logic [7:0] col,
                                        input logic [3:0] slot, input logic [63:0] rows);
    lcd_word_t w;
    w.req_type   = kind;
    w.byte_value = bv;
    w.row        = row;
    w.col        = col;
    w.glyph_slot = slot;
    w.glyph_rows = rows;
    return w;
  endfunction

  function automatic lcd_word_t any_word();
    return word_of(3'($urandom_range(7)), 8'($urandom_range(255)), 3'($urandom_range(7)),
                   8'($urandom_range(255)), 4'($urandom_range(15)), {$urandom, $urandom});
  endfunction

  // mostly ticks, some random words that land while busy and get refused
  function automatic lcd_word_t filler_word();
    lcd_word_t w;
    w = any_word();
    if ($urandom_range(99) >= 15) w.req_type = lcdn_pkg::REQ_TICK;
    return w;
  endfunction

  function automatic lcd_word_t rand_request(input int unsigned init_pct);
    lcd_word_t w;
    w = any_word();
    if ($urandom_range(99) < init_pct) begin
      w.req_type = lcdn_pkg::REQ_INIT;
    end else begin
      w.req_type = 3'($urandom_range(lcdn_pkg::REQ_GLYPH, lcdn_pkg::REQ_CMD));
    end
    if (w.req_type == lcdn_pkg::REQ_GLYPH) w.glyph_slot = 4'($urandom_range(7));
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus tasks
  // ---------------------------------------------------------------------------

  task automatic push_word(input lcd_word_t w);
    plan_state = lcd_next(plan_state, w);
    word_queue.push_back(w);
    words_pushed++;
  endtask

  // tick until the planned sequence is over
  task automatic settle();
    while (plan_state.ph != lcdn_pkg::PH_IDLE) push_word(filler_word());
  endtask

  task automatic request(input lcd_word_t w);
    push_word(w);
    settle();
  endtask

  // sender holds off until every result is back
  task automatic wait_drained();
    while (words_checked != words_pushed) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [lcdn_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lcdn_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    cfg_fired = 1'b0;
    do @(negedge clk); while (!cfg_fired);
    cfg_ch.valid <= 1'b0;
    plan_state = apply_reg(plan_state, idx, val);
  endtask

  task automatic reconfigure(input logic [15:0] long_wait, input logic [7:0] pulse);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(lcdn_pkg::CFG_LONG_WAIT, long_wait);
    write_reg(lcdn_pkg::CFG_PULSE, {8'd0, pulse});
    @(posedge clk);
  endtask

  // random traffic: requests placed while idle, ticks and noise while busy
  task automatic run_mix(input int unsigned n_words, input int unsigned init_pct);
    int unsigned start;
    start = words_pushed;
    while (words_pushed - start < n_words) begin
      if (plan_state.ph != lcdn_pkg::PH_IDLE) begin
        push_word(filler_word());
      end else if ($urandom_range(99) < 75) begin
        push_word(rand_request(init_pct));
      end else begin
        push_word(any_word());
      end
      if ($urandom_range(299) == 0) wait_drained();
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // driver: new word at the falling edge once the previous one was taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_words
    lcd_word_t nxt;
    out_ch.ready <= rst_n && ($urandom_range(99) >= gap_pct);
    if (!in_ch.valid || in_fired) begin
      if (rst_n && word_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nxt = word_queue.pop_front();
        in_ch.req_type   <= nxt.req_type;
        in_ch.byte_value <= nxt.byte_value;
        in_ch.row        <= nxt.row;
        in_ch.col        <= nxt.col;
        in_ch.glyph_slot <= nxt.glyph_slot;
        in_ch.glyph_rows <= nxt.glyph_rows;
        in_ch.valid      <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    in_fired = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each taken word, check each result word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    lcd_word_t      taken;
    lcdn_pkg::res_t want;
    lcdn_pkg::res_t got;
    if (rst_n) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("char_lcd_nibble_interface_unit_tb: errors");
        $finish;
      end else begin
        if (out_ch.valid && out_ch.ready) begin
          got.data_nibble = out_ch.data_nibble;
          got.reg_select  = out_ch.reg_select;
          got.enable_line = out_ch.enable_line;
          got.busy_res    = out_ch.busy_res;
          got.accepted    = out_ch.accepted;
          if (expected_levels.size() == 0) begin
            fault_count++;
            if (shown < MAX_SHOWN) begin
              shown++;
              $display("%0t: result word with nothing pending: %p", $time, got);
            end
          end else begin
            want = expected_levels.pop_front();
            if (got.data_nibble !== want.data_nibble || got.reg_select !== want.reg_select ||
                got.enable_line !== want.enable_line || got.busy_res !== want.busy_res ||
                got.accepted !== want.accepted) begin
              fault_count++;
              if (shown < MAX_SHOWN) begin
                shown++;
                $display("%0t: word %0d levels differ, expected %p, actual %p",
                         $time, words_checked, want, got);
              end
            end
            words_checked++;
          end
        end
        // a result never belongs to the word taken on the same edge
        if (in_ch.valid && in_ch.ready) begin
          taken = word_of(in_ch.req_type, in_ch.byte_value, in_ch.row, in_ch.col,
                          in_ch.glyph_slot, in_ch.glyph_rows);
          live_state = lcd_next(live_state, taken);
          want.data_nibble = live_state.nib;
          want.reg_select  = live_state.rs;
          want.enable_line = live_state.e;
          want.busy_res    = (live_state.ph != lcdn_pkg::PH_IDLE);
          want.accepted    = live_state.took;
          expected_levels.push_back(want);
          in_fired = 1'b1;
        end
        if (cfg_ch.valid && cfg_ch.ready) begin
          live_state = apply_reg(live_state, cfg_ch.index, cfg_ch.data);
          cfg_fired = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_n = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = lcdn_pkg::REQ_TICK;
    in_ch.byte_value = 8'd0;
    in_ch.row        = 3'd0;
    in_ch.col        = 8'd0;
    in_ch.glyph_slot = 4'd0;
    in_ch.glyph_rows = 64'd0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = lcdn_pkg::CFG_LONG_WAIT;
    cfg_ch.data      = '0;
    plan_state           = '0;
    plan_state.ph        = lcdn_pkg::PH_IDLE;
    plan_state.long_wait = lcdn_pkg::LONG_WAIT_RST;
    plan_state.pulse     = lcdn_pkg::PULSE_RST;
    live_state           = plan_state;

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);

    // directed words at reset settings: idle noise first, then each request kind
    push_word(word_of(lcdn_pkg::REQ_TICK, 8'hFF, 3'd7, 8'hFF, 4'hF, '1));
    push_word(word_of(REQ_SPARE, 8'h12, 3'd1, 8'h34, 4'd2, 64'd0));
    push_word(word_of(lcdn_pkg::REQ_GLYPH, 8'd0, 3'd0, 8'd0, 4'd8, '1));
    push_word(word_of(lcdn_pkg::REQ_GLYPH, 8'd0, 3'd0, 8'd0, 4'hF, 64'd0));
    request(word_of(lcdn_pkg::REQ_INIT, 8'd0, 3'd0, 8'd0, 4'd0, 64'd0));
    request(word_of(lcdn_pkg::REQ_CMD, 8'h00, 3'd0, 8'd0, 4'd0, 64'd0));
    // the second request here arrives while busy and must be refused
    push_word(word_of(lcdn_pkg::REQ_CMD, 8'hFF, 3'd0, 8'd0, 4'd0, 64'd0));
    push_word(word_of(lcdn_pkg::REQ_DATA, 8'h5A, 3'd0, 8'd0, 4'd0, 64'd0));
    settle();
    request(word_of(lcdn_pkg::REQ_DATA, 8'h00, 3'd0, 8'd0, 4'd0, 64'd0));
    request(word_of(lcdn_pkg::REQ_DATA, 8'hFF, 3'd0, 8'd0, 4'd0, 64'd0));
    request(word_of(lcdn_pkg::REQ_POS, 8'd0, 3'd0, 8'd0, 4'd0, 64'd0));
    request(word_of(lcdn_pkg::REQ_POS, 8'd0, 3'd3, 8'hFF, 4'd0, 64'd0));
    request(word_of(lcdn_pkg::REQ_POS, 8'd0, 3'd4, 8'd5, 4'd0, 64'd0));   // invalid row
    request(word_of(lcdn_pkg::REQ_POS, 8'd0, 3'd7, 8'hFF, 4'd0, 64'd0));
    // address wraps to zero
    request(word_of(lcdn_pkg::REQ_POS, 8'd0, 3'd1, 8'h40, 4'd0, 64'd0));
    request(word_of(lcdn_pkg::REQ_CPOS, 8'hA5, 3'd2, 8'd0, 4'd0, 64'd0));
    request(word_of(lcdn_pkg::REQ_CPOS, 8'h5A, 3'd5, 8'hFF, 4'd0, 64'd0));
    request(word_of(lcdn_pkg::REQ_GLYPH, 8'd0, 3'd0, 8'd0, 4'd0, '1));
    request(word_of(lcdn_pkg::REQ_GLYPH, 8'd0, 3'd0, 8'd0, 4'd7, 64'd0));
    request(word_of(lcdn_pkg::REQ_GLYPH, 8'hFF, 3'd6, 8'hFF, 4'd3, 64'h0123_4567_89AB_CDEF));

    // zero durations count as one tick; no idling on either side here
    reconfigure(16'd0, 8'd0);
    gap_pct = 0;
    run_mix(200, 5);
    gap_pct = 9;

    reconfigure(16'd1, 8'd1);
    run_mix(250, 5);
    reconfigure(16'd7, 8'd3);
    run_mix(250, 3);
    reconfigure(16'd20, 8'd2);
    run_mix(250, 3);

    // longer settings: one init, then a couple of slower byte sequences
    reconfigure(16'd40, 8'd6);
    request(word_of(lcdn_pkg::REQ_INIT, 8'd0, 3'd0, 8'd0, 4'd0, 64'd0));
    request(word_of(lcdn_pkg::REQ_CPOS, 8'hC3, 3'd3, 8'd10, 4'd0, 64'd0));
    request(word_of(lcdn_pkg::REQ_GLYPH, 8'd0, 3'd0, 8'd0, 4'd5, {$urandom, $urandom}));

    reconfigure(lcdn_pkg::LONG_WAIT_RST, lcdn_pkg::PULSE_RST);
    run_mix(200, 5);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_levels.size() != 0) fault_count++;
    if (fault_count == 0) begin
      $display("char_lcd_nibble_interface_unit_tb: clean");
    end else begin
      $display("char_lcd_nibble_interface_unit_tb: errors");
    end
    $finish;
  end

endmodule
